// ----- sv/sid_pkg.sv -----
// Package for the signed integer to decimal text unit.
// Holds widths, character codes, shared types and the leading digit search.
// No dependencies.
`default_nettype none

package sid_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef logic [3:0] bcd_digit_t;

  // Converted value handed from the cell row to the character emitter
  typedef struct packed {
    logic                             neg;
    bcd_digit_t [NUM_DIGITS-1:0]      digits;
  } conv_res_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_HOLD
  } conv_state_t;

  // Index of the most significant nonzero digit; zero when all digits are zero
  function automatic logic [IDX_W-1:0] msd_index(input bcd_digit_t [NUM_DIGITS-1:0] d);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[i] != 4'd0) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sid_ifs.sv -----
// Valid/ready channel interfaces of the signed integer to decimal text unit.
// Depends on sid_pkg for the field widths.
`default_nettype none

interface sid_in_if;
  import sid_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sid_out_if;
  import sid_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii_unit.sv -----
// Top level of the signed integer to decimal text unit.
// Depends on sid_pkg, sid_ifs, sid_conv, sid_cell and sid_emit.
//
// Usage:
//   in_ch  carries one signed 32-bit value per item (valid/ready).
//   out_ch carries the decimal text of each value, one ASCII character per
//   item, most significant first: a minus sign for negative values, then
//   the digits with leading zeros dropped; last marks the final character.
//   A value gives 1 to 11 characters.
// Conversion: an accepted value is shifted through the shift-and-add-3 digit
//   cell row, one magnitude bit per cycle, then held by the converter until
//   the emitter loads it and presents its first character on out_ch.
// Flow: the converter takes no new value while it is shifting; the emitter
//   sends one character per cycle while out_ch is ready. A new value is
//   taken while the previous one is still being sent.
// Reset clears both control stages; no items are pending afterwards.
// When out_ch stalls, the emitter holds its character, the converter holds
//   its finished value, and in_ch deasserts ready until space frees up.
`default_nettype none

module signed_int_to_decimal_ascii_unit
  import sid_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sid_in_if.sink     in_ch,
  sid_out_if.source  out_ch
);

  logic      res_valid;
  logic      res_ready;
  conv_res_t res;

  sid_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sid_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire

// ----- sv/sid_cell.sv -----
// One BCD digit cell of the shift-and-add-3 conversion row.
// Depends on sid_pkg for the digit type.
`default_nettype none

module sid_cell
  import sid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       clr,
  input  wire logic       shift,
  input  wire logic       shin,
  output      bcd_digit_t digit,
  output      logic       cout
);

  bcd_digit_t digit_r;
  bcd_digit_t digit_nxt;
  bcd_digit_t adj;

  // Add three when the digit would overflow a decimal place on doubling
  always_comb begin
    adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
    cout      = adj[3];
    digit_nxt = {adj[2:0], shin};
  end

  // Clear on load, advance one bit on shift, hold otherwise
  always_ff @(posedge clk) begin
    if (clr) begin
      digit_r <= '0;
    end else if (shift) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

`default_nettype wire

// ----- sv/sid_conv.sv -----
// Binary to BCD converter: magnitude shift register feeding a row of digit cells.
// Depends on sid_pkg and sid_cell.
`default_nettype none

module sid_conv
  import sid_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output      logic                      res_valid,
  input  wire logic                      res_ready,
  output      conv_res_t                 res
);

  conv_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]    mag_r;
  logic                  neg_r;
  logic                  load;
  logic                  shift;
  logic [NUM_DIGITS-1:0] carry;
  bcd_digit_t [NUM_DIGITS-1:0] digits;

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    in_ready  = 1'b0;
    shift     = 1'b0;
    unique case (state_r)
      CV_IDLE: begin
        in_ready = 1'b1;
      end
      CV_SHIFT: begin
        shift   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) state_nxt = CV_HOLD;
      end
      CV_HOLD: begin
        res_valid = 1'b1;
        in_ready  = res_ready;
        if (res_ready) state_nxt = CV_IDLE;
      end
      default: state_nxt = CV_IDLE;
    endcase
    load = in_valid && in_ready;
    if (load) begin
      state_nxt = CV_SHIFT;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Load the magnitude and sign, then shift the magnitude out msb first
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= in_value[VALUE_W-1];
      mag_r <= in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                   : VALUE_W'(in_value);
    end else if (shift) begin
      mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
    end
  end

  // Row of digit cells, least significant first
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    sid_cell u_cell (
      .clk   (clk),
      .clr   (load),
      .shift (shift),
      .shin  ((i == 0) ? mag_r[VALUE_W-1] : carry[(i == 0) ? 0 : i - 1]),
      .digit (digits[i]),
      .cout  (carry[i])
    );
  end

  assign res.neg    = neg_r;
  assign res.digits = digits;

endmodule

`default_nettype wire

// ----- sv/sid_emit.sv -----
// Character emitter: holds one converted value and sends its text msd first.
// Depends on sid_pkg.
`default_nettype none

module sid_emit
  import sid_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_valid,
  output      logic        res_ready,
  input  wire conv_res_t   res,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [CHAR_W-1:0] out_character,
  output      logic        out_last
);

  logic                        active_r;
  logic                        minus_r;
  logic [IDX_W-1:0]            idx_r;
  bcd_digit_t [NUM_DIGITS-1:0] digits_r;
  logic                        send;
  logic                        load;

  // Present the sign first, then digits down to the units place
  always_comb begin
    out_valid     = active_r;
    out_character = minus_r ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digits_r[idx_r]));
    out_last      = !minus_r && (idx_r == '0);
    send          = out_valid && out_ready;
    res_ready     = !active_r || (send && out_last);
    load          = res_valid && res_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (send && out_last) begin
      active_r <= 1'b0;
    end
  end

  // Take a new value, or advance one character per accepted item
  always_ff @(posedge clk) begin
    if (load) begin
      minus_r  <= res.neg;
      idx_r    <= msd_index(res.digits);
      digits_r <= res.digits;
    end else if (send) begin
      if (minus_r) begin
        minus_r <= 1'b0;
      end else if (idx_r != '0) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/signed_int_to_decimal_ascii_unit_tb.sv -----
// Testbench of signed_int_to_decimal_ascii_unit: directed, random and stalled
// values, each checked character by character against an in-bench predictor.
// Depends on sid_pkg, sid_ifs and the unit's RTL.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_tb;
  import sid_pkg::*;

  localparam int unsigned DEC_RADIX    = 10;
  localparam int          DRAIN_CYCLES = 45;
  localparam int          CYCLE_LIMIT  = 250000;

  // One character of expected decimal text
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sid_in_if  in_ch ();
  sid_out_if out_ch ();

  signed_int_to_decimal_ascii_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_char_t expected_text[$];
  int         error_count   = 0;
  int         values_sent   = 0;
  int         chars_checked = 0;
  int         cycle_count   = 0;
  int         src_idle_pct  = 0;
  int         dst_idle_pct  = 0;
  int         hold_left     = 0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters pending",
               cycle_count, expected_text.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Push the decimal text of one value onto the expected queue
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] value);
    bcd_digit_t         digs[NUM_DIGITS];
    logic [VALUE_W-1:0] mag;
    int                 count;
    mag   = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    count = 0;
    do begin
      digs[count] = bcd_digit_t'(mag % DEC_RADIX);
      mag         = mag / DEC_RADIX;
      count++;
    end while (mag != '0 && count < NUM_DIGITS);
    if (value[VALUE_W-1])
      expected_text.push_back('{character: CHAR_MINUS, last: 1'b0});
    for (int i = count - 1; i >= 0; i--)
      expected_text.push_back('{character: CHAR_ZERO + CHAR_W'(digs[i]), last: (i == 0)});
  endfunction

  // Pick a fully random value, or one with a random number of digits and a random sign
  function automatic logic [VALUE_W-1:0] pick_value();
    longint unsigned    bound;
    int unsigned        len;
    logic [VALUE_W-1:0] v;
    if ($urandom_range(3) == 0) begin
      v = $urandom;
    end else begin
      len   = $urandom_range(1, NUM_DIGITS);
      bound = 1;
      repeat (len) bound = bound * DEC_RADIX;
      v = VALUE_W'($urandom % bound);
      if ($urandom_range(1) == 1) v = VALUE_W'(0) - v;
    end
    return v;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character %0d, last %0b", out_ch.character, out_ch.last);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (out_ch.character !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, out_ch.character);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // Offer one value, with a random gap first, and hold it until accepted
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    queue_decimal_text(v);
    values_sent++;
  endtask

  // Drop valid and wait until every expected character has come out
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Zero, single digits, digit-count boundaries, both extremes, bit patterns
  task automatic test_directed_edges();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
             32'sd999999999, -32'sd999999999, 32'sd1000000000, -32'sd1000000000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
             32'hAAAA_AAAA, 32'sd1234567890, -32'sd7};
    src_idle_pct = 0;
    dst_idle_pct = 0;
    foreach (vals[i]) send_value(vals[i]);
    drain_pipeline();
  endtask

  // Random values under the given idle rates
  task automatic test_random_mix(input int n, input int src_pct, input int dst_pct);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    repeat (n) send_value(pick_value());
    drain_pipeline();
  endtask

  // Hold the receiver off for a long stretch so the unit stalls its input
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_left    = 400;
    repeat (20) send_value(pick_value());
    drain_pipeline();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_random_mix(50, 37, 68);
    test_random_mix(50, 68, 37);
    test_random_mix(40, 0, 0);
    test_output_backpressure();

    if (expected_text.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text.size());
      error_count++;
    end
    $display("Converted %0d values into %0d checked characters", values_sent, chars_checked);
    $display("Covered extremes, digit boundaries, idle mixes and a long output hold-off");
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
